>>> rtl/ill_pkg.sv
`timescale 1ns / 1ps

package ill_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 6;
    localparam int STAT_W   = 3;
    localparam int OCNT_W   = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_FETCH  = 3'd2,
        CMD_UPDATE = 3'd3,
        CMD_DELETE = 3'd4,
        CMD_POP    = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_BADPOS  = 3'd1,
        ST_FULL    = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_INVALID = 3'd4
    } t_status;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         index;
        t_status                  status;
        logic [OCNT_W-1:0]        count;
        logic                     last;
    } t_beat;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic [CNT_W-1:0] next;
        logic             gt;
        logic             lt;
        logic             eq;
    } t_step_res;

endpackage

>>> rtl/ill_ram.sv
`timescale 1ns / 1ps

module ill_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ill_step.sv
`timescale 1ns / 1ps

module ill_step (
    input  logic [ill_pkg::CNT_W-1:0] i_idx,
    input  logic [ill_pkg::CNT_W-1:0] i_bound,
    input  logic                      i_dec,
    output ill_pkg::t_step_res        o_res
);
    import ill_pkg::*;

    logic [CNT_W-1:0] w_next;

    // one incrementer/decrementer and one magnitude compare, shared by all loops
    assign w_next     = i_dec ? (i_idx - CNT_W'(1)) : (i_idx + CNT_W'(1));
    assign o_res.next = w_next;
    assign o_res.gt   = (w_next > i_bound);
    assign o_res.lt   = (w_next < i_bound);
    assign o_res.eq   = (w_next == i_bound);

endmodule

>>> rtl/ill_ctrl.sv
`timescale 1ns / 1ps

module ill_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_busy,
    input  logic [ill_pkg::CMD_W-1:0]        i_command,
    input  logic [ill_pkg::POS_W-1:0]        i_position,
    input  logic signed [ill_pkg::DATA_W-1:0] i_new_value,
    output ill_pkg::t_ram_req                o_ram,
    input  logic [ill_pkg::DATA_W-1:0]       i_rd_data,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output ill_pkg::t_beat                   o_res
);
    import ill_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SRD    = 7'b0000010,
        S_SWR    = 7'b0000100,
        S_PUT    = 7'b0001000,
        S_FRD    = 7'b0010000,
        S_FOUT   = 7'b0100000,
        S_RESULT = 7'b1000000
    } t_state;

    t_state           r_state,  n_state;
    logic [CNT_W-1:0] r_count,  n_count;
    logic [CNT_W-1:0] r_idx,    n_idx;
    logic [CNT_W-1:0] r_bound,  n_bound;
    logic             r_dec,    n_dec;
    logic             r_grow,   n_grow;
    t_status          r_status, n_status;
    logic [DATA_W-1:0] r_val,   n_val;

    t_step_res        w_step;
    logic [OCNT_W-1:0] w_cnt_ext;
    logic [OCNT_W-1:0] w_pos_ext;
    logic             w_full;
    logic             w_empty;
    logic             w_pos_bad;

    ill_step u_step (
        .i_idx   (r_idx),
        .i_bound (r_bound),
        .i_dec   (r_dec),
        .o_res   (w_step)
    );

    assign w_cnt_ext = OCNT_W'(r_count);
    assign w_pos_ext = OCNT_W'(i_position);
    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign w_empty   = (r_count == '0);
    assign w_pos_bad = (w_pos_ext >= w_cnt_ext);
    assign o_busy    = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_bound  = r_bound;
        n_dec    = r_dec;
        n_grow   = r_grow;
        n_status = r_status;
        n_val    = r_val;

        o_ram       = '0;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.count = w_cnt_ext;
        o_res.last  = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_val    = i_new_value;
                    n_status = ST_OK;
                    n_grow   = 1'b0;
                    n_dec    = 1'b0;
                    n_state  = S_RESULT;
                    unique case (t_cmd'(i_command))
                        CMD_INSERT: begin
                            if (w_pos_bad) begin
                                n_status = ST_BADPOS;
                            end else if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                // shift from the tail down to the insert point
                                n_idx   = r_count;
                                n_bound = CNT_W'(i_position);
                                n_dec   = 1'b1;
                                n_grow  = 1'b1;
                                n_state = S_SRD;
                            end
                        end
                        CMD_APPEND: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_idx   = r_count;
                                n_grow  = 1'b1;
                                n_state = S_PUT;
                            end
                        end
                        CMD_FETCH: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_idx   = '0;
                                n_bound = r_count;
                                n_state = S_FRD;
                            end
                        end
                        CMD_UPDATE: begin
                            if (w_pos_bad) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_idx   = CNT_W'(i_position);
                                n_state = S_PUT;
                            end
                        end
                        CMD_DELETE: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else if (w_pos_bad) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_idx   = CNT_W'(i_position);
                                n_bound = r_count;
                                n_state = S_SRD;
                            end
                        end
                        CMD_POP: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        default: begin
                            n_status = ST_INVALID;
                        end
                    endcase
                end
            end

            S_SRD: begin
                // insert always has a neighbor to pull; delete stops at the tail
                if (r_dec || w_step.lt) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = w_step.next[ADDR_W-1:0];
                    n_state     = S_SWR;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_RESULT;
                end
            end

            S_SWR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_idx[ADDR_W-1:0];
                o_ram.wdata = i_rd_data;
                n_idx       = w_step.next;
                if (r_dec) begin
                    n_state = w_step.gt ? S_SRD : S_PUT;
                end else begin
                    n_state = S_SRD;
                end
            end

            S_PUT: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_idx[ADDR_W-1:0];
                o_ram.wdata = r_val;
                if (r_grow) begin
                    n_count = r_count + CNT_W'(1);
                end
                n_state = S_RESULT;
            end

            S_FRD: begin
                o_ram.re    = 1'b1;
                o_ram.raddr = r_idx[ADDR_W-1:0];
                n_state     = S_FOUT;
            end

            S_FOUT: begin
                o_res_valid = 1'b1;
                o_res.value = i_rd_data;
                o_res.index = POS_W'(r_idx);
                o_res.last  = w_step.eq;
                if (i_res_ready) begin
                    if (w_step.eq) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = w_step.next;
                        n_state = S_FRD;
                    end
                end
            end

            S_RESULT: begin
                o_res_valid  = 1'b1;
                o_res.status = r_status;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx    <= n_idx;
        r_bound  <= n_bound;
        r_dec    <= n_dec;
        r_grow   <= n_grow;
        r_status <= n_status;
        r_val    <= n_val;
    end

endmodule

>>> rtl/indexed_list_insert_delete.sv
`timescale 1ns / 1ps
// Sequence: update and append write the entry (S_PUT), then report (S_RESULT); insert
// first moves entries up, delete moves entries down; pop, errors and invalid commands
// go straight to S_RESULT. One command at a time on the single-port-pair list RAM: a moved
// entry is read (S_SRD), then written (S_SWR); fetch reads, then presents, each entry.
// Reset (synchronous, active low) empties the list and idles the sequencer; the
// entry RAM keeps its contents and is never read beyond the held count.

module indexed_list_insert_delete (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [ill_pkg::CMD_W-1:0]         i_command,
    input  logic [ill_pkg::POS_W-1:0]         i_position,
    input  logic signed [ill_pkg::DATA_W-1:0] i_new_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [ill_pkg::DATA_W-1:0] o_entry_value,
    output logic [ill_pkg::POS_W-1:0]         o_entry_index,
    output logic [ill_pkg::STAT_W-1:0]        o_status,
    output logic [ill_pkg::OCNT_W-1:0]        o_entry_count,
    output logic                              o_last
);
    import ill_pkg::*;

    t_ram_req          w_ram;
    logic [DATA_W-1:0] w_rd_data;
    logic              w_busy;
    logic              w_res_valid;
    logic              w_res_ready;
    t_beat             w_res;

    logic  r_o_valid, n_o_valid;
    t_beat r_beat,    n_beat;

    ill_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_re    (w_ram.re),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rd_data)
    );

    ill_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_busy      (w_busy),
        .i_command   (i_command),
        .i_position  (i_position),
        .i_new_value (i_new_value),
        .o_ram       (w_ram),
        .i_rd_data   (w_rd_data),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // output register frees the sequencer as soon as a beat is handed over
    assign w_res_ready = !r_o_valid || !i_stall;

    always_comb begin
        n_o_valid = r_o_valid;
        n_beat    = r_beat;
        if (w_res_ready) begin
            n_o_valid = w_res_valid;
            if (w_res_valid) begin
                n_beat = w_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
        end
        r_beat <= n_beat;
    end

    assign o_stall       = w_busy;
    assign o_valid       = r_o_valid;
    assign o_entry_value = r_beat.value;
    assign o_entry_index = r_beat.index;
    assign o_status      = r_beat.status;
    assign o_entry_count = r_beat.count;
    assign o_last        = r_beat.last;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entry_count <= OCNT_W'(CAPACITY)))
        else $error("entry count above capacity");

    a_mid_fetch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (o_status == ST_OK))
        else $error("non-final beat without ok status");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> ((o_entry_value == '0) && (o_entry_index == '0)))
        else $error("error beat carries data");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("sequencer idle right after accepting a command");

endmodule
